[rtl/ntp_time_line_parser_macros.svh]
// assertion helpers for the time line parser
`ifndef NTP_TIME_LINE_PARSER_MACROS_SVH
`define NTP_TIME_LINE_PARSER_MACROS_SVH

// clocked check, off while reset is asserted
`define NTP_TLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define NTP_TLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/ntp_tlp_pkg.sv]
package ntp_tlp_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 6;
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int FIELD2_W  = 7;
    localparam int WEEKDAY_W = 3;

    localparam logic [POS_W-1:0] PREFIX_END  = 6'd12;
    localparam logic [POS_W-1:0] WDAY_POS0   = 6'd13;
    localparam logic [POS_W-1:0] WDAY_POS1   = 6'd14;
    localparam logic [POS_W-1:0] WDAY_POS2   = 6'd15;
    localparam logic [POS_W-1:0] MON_POS0    = 6'd17;
    localparam logic [POS_W-1:0] MON_POS1    = 6'd18;
    localparam logic [POS_W-1:0] MON_POS2    = 6'd19;
    localparam logic [POS_W-1:0] DAY_POS0    = 6'd21;
    localparam logic [POS_W-1:0] DAY_POS1    = 6'd22;
    localparam logic [POS_W-1:0] HOUR_POS0   = 6'd24;
    localparam logic [POS_W-1:0] HOUR_POS1   = 6'd25;
    localparam logic [POS_W-1:0] MIN_POS0    = 6'd27;
    localparam logic [POS_W-1:0] MIN_POS1    = 6'd28;
    localparam logic [POS_W-1:0] SEC_POS0    = 6'd30;
    localparam logic [POS_W-1:0] SEC_POS1    = 6'd31;
    localparam logic [POS_W-1:0] YEAR_POS0   = 6'd33;
    localparam logic [POS_W-1:0] YEAR_POS3   = 6'd36;
    localparam logic [POS_W-1:0] POS_MAX     = 6'd63;

    localparam logic [YEAR_W-1:0] UNSYNCED_YEAR_RESET = 14'd1970;

    localparam logic [MONTH_W-1:0]   MONTH_DEFAULT   = 4'd12;
    localparam logic [WEEKDAY_W-1:0] WEEKDAY_DEFAULT = 3'd6;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [FIELD2_W-1:0]  day;
        logic [FIELD2_W-1:0]  hour;
        logic [FIELD2_W-1:0]  minute;
        logic [FIELD2_W-1:0]  second;
        logic [WEEKDAY_W-1:0] weekday;
        logic                 prefix_ok;
        logic                 format_ok;
        logic                 time_valid;
    } t_result;

    function automatic logic [BYTE_W-1:0] prefix_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = "+";
            4'd1:    c = "C";
            4'd2:    c = "I";
            4'd3:    c = "P";
            4'd4:    c = "S";
            4'd5:    c = "N";
            4'd6:    c = "T";
            4'd7:    c = "P";
            4'd8:    c = "T";
            4'd9:    c = "I";
            4'd10:   c = "M";
            4'd11:   c = "E";
            4'd12:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    // non-digits count as zero
    function automatic logic [3:0] digit_val(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b - "0";
        return is_digit(b) ? d[3:0] : 4'd0;
    endfunction

    function automatic logic [MONTH_W-1:0] decode_month(input logic [23:0] c);
        logic [MONTH_W-1:0] m;
        unique case (c)
            "Jan":   m = 4'd1;
            "Feb":   m = 4'd2;
            "Mar":   m = 4'd3;
            "Apr":   m = 4'd4;
            "May":   m = 4'd5;
            "Jun":   m = 4'd6;
            "Jul":   m = 4'd7;
            "Aug":   m = 4'd8;
            "Sep":   m = 4'd9;
            "Oct":   m = 4'd10;
            "Nov":   m = 4'd11;
            default: m = MONTH_DEFAULT;
        endcase
        return m;
    endfunction

    function automatic logic [WEEKDAY_W-1:0] decode_weekday(input logic [23:0] c);
        logic [WEEKDAY_W-1:0] w;
        unique case (c)
            "Sun":   w = 3'd0;
            "Mon":   w = 3'd1;
            "Tue":   w = 3'd2;
            "Wed":   w = 3'd3;
            "Thu":   w = 3'd4;
            "Fri":   w = 3'd5;
            default: w = WEEKDAY_DEFAULT;
        endcase
        return w;
    endfunction

endpackage

[rtl/ntp_tlp_line.sv]
module ntp_tlp_line (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic [ntp_tlp_pkg::BYTE_W-1:0]      i_byte,
    input  logic                                i_last,
    input  logic [ntp_tlp_pkg::YEAR_W-1:0]      i_unsynced_year,
    output ntp_tlp_pkg::t_result                o_result
);
    import ntp_tlp_pkg::*;

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [23:0]         r_wday, n_wday;
    logic [23:0]         r_mon, n_mon;
    logic [FIELD2_W-1:0] r_day, n_day;
    logic [FIELD2_W-1:0] r_hour, n_hour;
    logic [FIELD2_W-1:0] r_min, n_min;
    logic [FIELD2_W-1:0] r_sec, n_sec;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic                r_pre, n_pre;
    logic                r_dig, n_dig;
    logic [3:0]          dval;
    logic                pre_ok;
    logic                fmt_ok;

    assign dval = digit_val(i_byte);

    always_comb begin
        n_pos  = (r_pos == POS_MAX) ? r_pos : r_pos + 6'd1;
        n_wday = r_wday;
        n_mon  = r_mon;
        n_day  = r_day;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_year = r_year;
        n_pre  = r_pre;
        n_dig  = r_dig;
        if (r_pos <= PREFIX_END) begin
            if (i_byte != prefix_char(r_pos[3:0])) begin
                n_pre = 1'b0;
            end
        end else if (r_pos == WDAY_POS0) begin
            n_wday[23:16] = i_byte;
        end else if (r_pos == WDAY_POS1) begin
            n_wday[15:8] = i_byte;
        end else if (r_pos == WDAY_POS2) begin
            n_wday[7:0] = i_byte;
        end else if (r_pos == MON_POS0) begin
            n_mon[23:16] = i_byte;
        end else if (r_pos == MON_POS1) begin
            n_mon[15:8] = i_byte;
        end else if (r_pos == MON_POS2) begin
            n_mon[7:0] = i_byte;
        end else if (r_pos == DAY_POS0 || r_pos == DAY_POS1) begin
            n_day = FIELD2_W'(r_day * 7'd10 + FIELD2_W'(dval));
            n_dig = r_dig & is_digit(i_byte);
        end else if (r_pos == HOUR_POS0 || r_pos == HOUR_POS1) begin
            n_hour = FIELD2_W'(r_hour * 7'd10 + FIELD2_W'(dval));
            n_dig  = r_dig & is_digit(i_byte);
        end else if (r_pos == MIN_POS0 || r_pos == MIN_POS1) begin
            n_min = FIELD2_W'(r_min * 7'd10 + FIELD2_W'(dval));
            n_dig = r_dig & is_digit(i_byte);
        end else if (r_pos == SEC_POS0 || r_pos == SEC_POS1) begin
            n_sec = FIELD2_W'(r_sec * 7'd10 + FIELD2_W'(dval));
            n_dig = r_dig & is_digit(i_byte);
        end else if (r_pos >= YEAR_POS0 && r_pos <= YEAR_POS3) begin
            n_year = YEAR_W'(r_year * 14'd10 + YEAR_W'(dval));
            n_dig  = r_dig & is_digit(i_byte);
        end
    end

    assign pre_ok = n_pre && (r_pos >= PREFIX_END);
    assign fmt_ok = n_dig && (r_pos >= YEAR_POS3);

    always_comb begin
        o_result.year       = n_year;
        o_result.month      = decode_month(n_mon);
        o_result.day        = n_day;
        o_result.hour       = n_hour;
        o_result.minute     = n_min;
        o_result.second     = n_sec;
        o_result.weekday    = decode_weekday(n_wday);
        o_result.prefix_ok  = pre_ok;
        o_result.format_ok  = fmt_ok;
        o_result.time_valid = pre_ok && fmt_ok && (n_year != i_unsynced_year);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_pos  <= '0;
            r_wday <= '0;
            r_mon  <= '0;
            r_day  <= '0;
            r_hour <= '0;
            r_min  <= '0;
            r_sec  <= '0;
            r_year <= '0;
            r_pre  <= 1'b1;
            r_dig  <= 1'b1;
        end else if (i_take) begin
            r_pos  <= n_pos;
            r_wday <= n_wday;
            r_mon  <= n_mon;
            r_day  <= n_day;
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
            r_year <= n_year;
            r_pre  <= n_pre;
            r_dig  <= n_dig;
        end
    end

endmodule

[rtl/ntp_time_line_parser.sv]
// Parses a modem time reply line "+CIPSNTPTIME:Www Mmm DD hh:mm:ss YYYY" one
// byte per word on the slave stream, tlast marking the line's last byte. The
// block takes one word every cycle while the result stream is not stalled:
// each byte goes through an input register and then an update of the per-line
// position, name and digit registers. The word with tlast, once taken from the
// input register, gives one registered result word; other bytes give none.
// Result tdata holds, from bit 0 up: year[13:0], month[17:14] (1-12, unknown
// name 12), day[24:18], hour[31:25], minute[38:32], second[45:39],
// weekday[48:46] (0 = Sunday, unknown name 6), zeros to bit 55. tuser holds
// prefix_ok, format_ok and time_valid; time_valid is low when the year equals
// the configured unsynchronized year (1970 after reset). Write that year only
// while no line is in flight.
`include "ntp_time_line_parser_macros.svh"

module ntp_time_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata,     // unsynced_year
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // rx_byte
    input  logic        s_axis_tlast,    // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,    // year, month, day, hour, minute, second, weekday
    output logic [2:0]  m_axis_tuser     // prefix_ok, format_ok, time_valid
);
    import ntp_tlp_pkg::*;

    logic [YEAR_W-1:0] r_unsynced_year;
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;
    t_result           line_result;
    logic              s_accept;
    logic              take;

    assign take          = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || take;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    ntp_tlp_line u_line (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_byte          (r_in_byte),
        .i_last          (r_in_last),
        .i_unsynced_year (r_unsynced_year),
        .o_result        (line_result)
    );

    always_comb begin
        n_in_valid  = s_accept ? 1'b1 : (take ? 1'b0 : r_in_valid);
        n_out_valid = (take && r_in_last) ? 1'b1 :
                      (m_axis_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unsynced_year <= UNSYNCED_YEAR_RESET;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unsynced_year <= i_cfg_wdata;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (take && r_in_last) begin
            r_out <= line_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.weekday, r_out.second, r_out.minute,
                            r_out.hour, r_out.day, r_out.month, r_out.year};
    assign m_axis_tuser  = {r_out.time_valid, r_out.format_ok, r_out.prefix_ok};

    `NTP_TLP_ASSERT(a_last_gives_result, take && r_in_last |=> m_axis_tvalid, "line end lost")
    `NTP_TLP_ASSERT(a_result_from_last, $rose(m_axis_tvalid) |-> $past(take && r_in_last), "result without line end")
    `NTP_TLP_ASSERT(a_valid_implies_ok, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1] && m_axis_tuser[0], "time valid without prefix and format")
    `NTP_TLP_ASSERT(a_month_range, m_axis_tvalid |-> (r_out.month != 4'd0) && (r_out.month <= MONTH_DEFAULT), "month out of range")
    `NTP_TLP_ASSERT_ALWAYS(a_reset_clears, !$past(i_rst_n) |-> !m_axis_tvalid && !r_in_valid, "reset did not clear valids")

endmodule

[tb/ntp_time_line_parser_tb.sv]
module ntp_time_line_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ntp_tlp_pkg::*;

    localparam logic [103:0] PREFIX_TEXT = "+CIPSNTPTIME:";
    localparam logic [7:0] SPACE_CHAR = " ";
    localparam logic [7:0] COLON_CHAR = ":";
    localparam logic [7:0] ZERO_CHAR = "0";
    localparam logic [7:0] NINE_CHAR = "9";
    localparam logic [23:0] DAY_CODES [7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
    localparam logic [23:0] MONTH_CODES [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                                 "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [13:0] i_cfg_wdata;     // unsynced_year
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // rx_byte
    logic        s_axis_tlast;    // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;    // year, month, day, hour, minute, second, weekday
    logic [2:0]  m_axis_tuser;    // prefix_ok, format_ok, time_valid

    ntp_time_line_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // line state mirrored from the parser
    logic [5:0]  line_pos;
    logic [23:0] wday_seen;
    logic [23:0] mon_seen;
    logic [6:0]  day_sum;
    logic [6:0]  hour_sum;
    logic [6:0]  min_sum;
    logic [6:0]  sec_sum;
    logic [13:0] year_sum;
    logic        prefix_good;
    logic        digits_good;
    logic [13:0] unsynced_cfg;

    t_result     expected_times[$];
    t_result     want_time;
    logic [7:0]  line_q[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ntp_time_line_parser_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // random wait per word, with occasional runs of back-to-back words
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
        end
        return $urandom_range(0, 14);
    endfunction

    task automatic clear_line_state();
        line_pos = '0;
        wday_seen = '0;
        mon_seen = '0;
        day_sum = '0;
        hour_sum = '0;
        min_sum = '0;
        sec_sum = '0;
        year_sum = '0;
        prefix_good = 1'b1;
        digits_good = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int p;
        int dval;
        logic is_dig;
        t_result r;
        p = int'(line_pos);
        is_dig = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
        dval = is_dig ? int'(b) - int'(ZERO_CHAR) : 0;
        if (p < 13) begin
            if (b != PREFIX_TEXT[8*(12-p) +: 8]) prefix_good = 1'b0;
        end else if (p <= 15) begin
            wday_seen[8*(15-p) +: 8] = b;
        end else if (p >= 17 && p <= 19) begin
            mon_seen[8*(19-p) +: 8] = b;
        end else begin
            case (p)
                21, 22: day_sum = 7'(int'(day_sum) * 10 + dval);
                24, 25: hour_sum = 7'(int'(hour_sum) * 10 + dval);
                27, 28: min_sum = 7'(int'(min_sum) * 10 + dval);
                30, 31: sec_sum = 7'(int'(sec_sum) * 10 + dval);
                33, 34, 35, 36: year_sum = 14'(int'(year_sum) * 10 + dval);
                default: ;
            endcase
            if (p inside {21, 22, 24, 25, 27, 28, 30, 31, [33:36]} && !is_dig) begin
                digits_good = 1'b0;
            end
        end
        if (line_pos != POS_MAX) line_pos++;
        if (last) begin
            r.year = year_sum;
            r.month = MONTH_DEFAULT;
            for (int i = 0; i < 11; i++) begin
                if (mon_seen == MONTH_CODES[i]) r.month = 4'(i + 1);
            end
            r.weekday = WEEKDAY_DEFAULT;
            for (int i = 0; i < 6; i++) begin
                if (wday_seen == DAY_CODES[i]) r.weekday = 3'(i);
            end
            r.day = day_sum;
            r.hour = hour_sum;
            r.minute = min_sum;
            r.second = sec_sum;
            r.prefix_ok = prefix_good && (p + 1 >= 13);
            r.format_ok = digits_good && (p + 1 >= 37);
            r.time_valid = r.prefix_ok && r.format_ok && (year_sum != unsynced_cfg);
            expected_times.push_back(r);
            clear_line_state();
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_byte(b, last);
        words_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++) begin
            send_word(line_q[i], i == line_q.size() - 1);
        end
        line_q.delete();
    endtask

    task automatic push_code(input logic [23:0] c);
        line_q.push_back(c[23:16]);
        line_q.push_back(c[15:8]);
        line_q.push_back(c[7:0]);
    endtask

    task automatic push_num(input int v, input int nd);
        int scale;
        scale = (nd == 4) ? 1000 : 10;
        repeat (nd) begin
            line_q.push_back(8'(int'(ZERO_CHAR) + (v / scale) % 10));
            scale = scale / 10;
        end
    endtask

    task automatic load_line(input int wd, input int mo, input int dd, input int hh,
                             input int mi, input int ss, input int yy);
        for (int i = 0; i < 13; i++) begin
            line_q.push_back(PREFIX_TEXT[8*(12-i) +: 8]);
        end
        push_code(DAY_CODES[wd]);
        line_q.push_back(SPACE_CHAR);
        push_code(MONTH_CODES[mo]);
        line_q.push_back(SPACE_CHAR);
        push_num(dd, 2);
        line_q.push_back(SPACE_CHAR);
        push_num(hh, 2);
        line_q.push_back(COLON_CHAR);
        push_num(mi, 2);
        line_q.push_back(COLON_CHAR);
        push_num(ss, 2);
        line_q.push_back(SPACE_CHAR);
        push_num(yy, 4);
    endtask

    task automatic cut_line(input int n);
        while (line_q.size() > n) void'(line_q.pop_back());
    endtask

    task automatic add_junk(input int n);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // idle point: nothing in flight on either side
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_times.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_unsynced(input logic [13:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        unsynced_cfg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_year();
        load_line(6, 11, 31, 23, 59, 59, 1970);
        send_line();
        load_line(0, 0, 1, 0, 0, 0, 2024);
        send_line();
    endtask

    task automatic test_names();
        for (int i = 0; i < 12; i++) begin
            load_line(i % 7, i, i + 1, i, 2 * i, 3 * i, 2000 + i);
            send_line();
        end
    endtask

    task automatic test_digit_extremes();
        load_line(3, 5, 0, 0, 0, 0, 0);
        send_line();
        load_line(4, 6, 99, 99, 99, 99, 9999);
        send_line();
    endtask

    task automatic test_bad_digits();
        load_line(1, 1, 12, 10, 20, 30, 2031);
        line_q[21] = "x";
        line_q[24] = "/";
        send_line();
        load_line(2, 2, 5, 6, 7, 8, 2042);
        line_q[31] = COLON_CHAR;
        line_q[36] = 8'hff;
        send_line();
    endtask

    task automatic test_bad_prefix();
        load_line(5, 7, 15, 12, 0, 1, 2050);
        line_q[0] = "-";
        send_line();
        load_line(5, 8, 16, 13, 1, 2, 2051);
        line_q[12] = SPACE_CHAR;
        send_line();
    endtask

    task automatic test_short_lines();
        int lens [5] = '{1, 12, 13, 18, 36};
        foreach (lens[k]) begin
            load_line(k, k + 3, 28, 22, 33, 44, 2099);
            cut_line(lens[k]);
            send_line();
        end
    endtask

    task automatic test_long_line();
        load_line(0, 10, 9, 8, 7, 6, 1999);
        add_junk(40);
        send_line();
    endtask

    task automatic test_unsynced_setting();
        write_unsynced(14'd0);
        load_line(1, 0, 1, 1, 1, 1, 0);
        send_line();
        load_line(1, 0, 1, 1, 1, 1, 1);
        send_line();
        write_unsynced(14'd9999);
        load_line(2, 3, 4, 5, 6, 7, 9999);
        send_line();
    endtask

    task automatic random_line();
        int kind;
        int yy;
        kind = $urandom_range(0, 99);
        yy = ($urandom_range(0, 4) == 0) ? int'(unsynced_cfg) : $urandom_range(0, 9999);
        if (kind < 90) begin
            load_line($urandom_range(0, 6), $urandom_range(0, 11), $urandom_range(0, 99),
                      $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99), yy);
        end
        if (kind >= 62 && kind < 72) begin
            repeat ($urandom_range(1, 3)) line_q[$urandom_range(0, 36)] = 8'($urandom_range(0, 255));
        end else if (kind >= 72 && kind < 82) begin
            cut_line($urandom_range(1, 36));
        end else if (kind >= 82 && kind < 90) begin
            add_junk($urandom_range(1, 33));
        end else if (kind >= 90) begin
            add_junk($urandom_range(1, 45));
        end
        send_line();
    endtask

    task automatic test_random_traffic(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) random_line();
    endtask

    // result side: random stall before each word
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_wait(rx_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_times.size() == 0) begin
                report_mismatch("result word with no line pending");
            end else begin
                want_time = expected_times.pop_front();
                check_field("year", m_axis_tdata[13:0], want_time.year);
                check_field("month", m_axis_tdata[17:14], want_time.month);
                check_field("day", m_axis_tdata[24:18], want_time.day);
                check_field("hour", m_axis_tdata[31:25], want_time.hour);
                check_field("minute", m_axis_tdata[38:32], want_time.minute);
                check_field("second", m_axis_tdata[45:39], want_time.second);
                check_field("weekday", m_axis_tdata[48:46], want_time.weekday);
                check_field("prefix_ok", m_axis_tuser[0], want_time.prefix_ok);
                check_field("format_ok", m_axis_tuser[1], want_time.format_ok);
                check_field("time_valid", m_axis_tuser[2], want_time.time_valid);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        unsynced_cfg = UNSYNCED_YEAR_RESET;
        clear_line_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_year();
        test_names();
        test_digit_extremes();
        test_bad_digits();
        test_bad_prefix();
        test_short_lines();
        test_long_line();
        test_unsynced_setting();

        write_unsynced(14'($urandom_range(0, 9999)));
        test_random_traffic(150);
        write_unsynced(14'd0);
        test_random_traffic(150);
        write_unsynced(14'd9999);
        test_random_traffic(150);
        write_unsynced(UNSYNCED_YEAR_RESET);
        test_random_traffic(150);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ntp_time_line_parser_tb: done, clean");
        end else begin
            $display("ntp_time_line_parser_tb: done, errors");
        end
        $finish;
    end

endmodule
